### design/stde_pkg.sv
package stde_pkg;

    // operation codes
    localparam logic [1:0] OP_SAMPLE    = 2'd0;
    localparam logic [1:0] OP_CLEAR_DEV = 2'd1;
    localparam logic [1:0] OP_CLEAR_ALL = 2'd2;

    // direction codes, also the bit position in a flag nibble
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    localparam logic [14:0] THRESH_RESET = 15'd16384;

    // slots in the job queue between front and back
    localparam int JOB_DEPTH = 2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [3:0]         device_index;
        logic               stick_select;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic [31:0]        time_stamp;
    } t_in_word;

    typedef struct packed {
        logic [3:0]  event_device;
        logic        event_stick;
        logic [1:0]  direction;
        logic        pressed;
        logic [31:0] event_time;
        logic        last_event;
    } t_out_word;

    // one classified sample: which flags to release and which to press
    typedef struct packed {
        logic [3:0]  device;
        logic        stick;
        logic [3:0]  rel_mask;
        logic [3:0]  prs_mask;
        logic [31:0] time_stamp;
    } t_job;

endpackage

### design/stde_front.sv
module stde_front #(
    parameter int DEVICE_COUNT = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  stde_pkg::t_in_word i_word,
    input  logic [14:0]        i_threshold,
    output logic               o_job_push,
    output stde_pkg::t_job     o_job
);

    localparam int USED_DEV = (DEVICE_COUNT < 16) ? DEVICE_COUNT : 16;
    localparam int ENTRIES  = 2 * USED_DEV;
    localparam int IDXW     = $clog2(ENTRIES);

    logic [3:0]         r_flags [ENTRIES];
    logic               dev_ok;
    logic [IDXW-1:0]    idx;
    logic [3:0]         old_flags;
    logic [3:0]         want;
    logic signed [16:0] x_ext;
    logic signed [16:0] y_ext;
    logic signed [16:0] th_pos;
    logic signed [16:0] th_neg;

    assign dev_ok    = int'(i_word.device_index) < USED_DEV;
    assign idx       = IDXW'({i_word.device_index, i_word.stick_select});
    assign old_flags = r_flags[idx];

    assign x_ext  = {i_word.axis_x[15], i_word.axis_x};
    assign y_ext  = {i_word.axis_y[15], i_word.axis_y};
    assign th_pos = {2'b00, i_threshold};
    assign th_neg = -th_pos;

    always_comb begin
        want = 4'b0000;
        want[stde_pkg::DIR_UP]    = y_ext < th_neg;
        want[stde_pkg::DIR_DOWN]  = y_ext > th_pos;
        want[stde_pkg::DIR_LEFT]  = x_ext < th_neg;
        want[stde_pkg::DIR_RIGHT] = x_ext > th_pos;
    end

    always_comb begin
        o_job.device     = i_word.device_index;
        o_job.stick      = i_word.stick_select;
        o_job.rel_mask   = old_flags & ~want;
        o_job.prs_mask   = ~old_flags & want;
        o_job.time_stamp = i_word.time_stamp;
    end

    // a sample with no flag change needs no job
    assign o_job_push = i_accept && (i_word.operation == stde_pkg::OP_SAMPLE) && dev_ok
                        && ((o_job.rel_mask | o_job.prs_mask) != 4'b0000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < ENTRIES; e++) begin
                r_flags[e] <= 4'b0000;
            end
        end else if (i_accept) begin
            if (i_word.operation == stde_pkg::OP_CLEAR_ALL) begin
                for (int e = 0; e < ENTRIES; e++) begin
                    r_flags[e] <= 4'b0000;
                end
            end else if (i_word.operation == stde_pkg::OP_CLEAR_DEV && dev_ok) begin
                for (int e = 0; e < ENTRIES; e++) begin
                    if (int'(i_word.device_index) == e / 2) begin
                        r_flags[e] <= 4'b0000;
                    end
                end
            end else if (i_word.operation == stde_pkg::OP_SAMPLE && dev_ok) begin
                r_flags[idx] <= want;
            end
        end
    end

endmodule

### design/stde_job_fifo.sv
module stde_job_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  stde_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output stde_pkg::t_job o_job
);

    localparam int DEPTH = stde_pkg::JOB_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    stde_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push;
    logic           do_pop;

    assign o_valid = r_count != '0;
    assign o_full  = r_count == CW'(DEPTH);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### design/stde_back.sv
module stde_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  stde_pkg::t_job      i_job,
    output logic                o_job_pop,
    input  logic                i_pop,
    output logic                o_out_valid,
    output stde_pkg::t_out_word o_out
);

    logic                r_busy;
    stde_pkg::t_job      r_job;
    logic                r_out_valid;
    stde_pkg::t_out_word r_out;
    logic                rel_any;
    logic [3:0]          sel_mask;
    logic [1:0]          sel_dir;
    logic [3:0]          sel_bit;
    logic [3:0]          n_rel;
    logic [3:0]          n_prs;
    logic                last;
    logic                adv;
    logic                pop_ok;
    logic                take_job;

    function automatic logic [1:0] low_bit(input logic [3:0] m);
        priority if (m[0]) low_bit = stde_pkg::DIR_UP;
        else if (m[1])     low_bit = stde_pkg::DIR_DOWN;
        else if (m[2])     low_bit = stde_pkg::DIR_LEFT;
        else               low_bit = stde_pkg::DIR_RIGHT;
    endfunction

    // releases drain before presses
    assign rel_any  = r_job.rel_mask != 4'b0000;
    assign sel_mask = rel_any ? r_job.rel_mask : r_job.prs_mask;
    assign sel_dir  = low_bit(sel_mask);
    assign sel_bit  = 4'b0001 << sel_dir;
    assign n_rel    = rel_any ? (r_job.rel_mask & ~sel_bit) : r_job.rel_mask;
    assign n_prs    = rel_any ? r_job.prs_mask : (r_job.prs_mask & ~sel_bit);
    assign last     = (n_rel | n_prs) == 4'b0000;

    assign pop_ok   = i_pop && r_out_valid;
    assign adv      = r_busy && (!r_out_valid || pop_ok);
    assign take_job = i_job_valid && (!r_busy || (adv && last));

    assign o_job_pop   = take_job;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (pop_ok) begin
                r_out_valid <= 1'b0;
            end
            if (take_job) begin
                r_busy <= 1'b1;
            end else if (adv) begin
                r_busy <= !last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.event_device <= r_job.device;
            r_out.event_stick  <= r_job.stick;
            r_out.direction    <= sel_dir;
            r_out.pressed      <= !rel_any;
            r_out.event_time   <= r_job.time_stamp;
            r_out.last_event   <= last;
        end
        if (take_job) begin
            r_job <= i_job;
        end else if (adv) begin
            r_job.rel_mask <= n_rel;
            r_job.prs_mask <= n_prs;
        end
    end

    a_busy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ((r_job.rel_mask | r_job.prs_mask) != 4'b0000))
        else $error("busy job with no events left");

    a_mid_job_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last_event) |-> r_busy)
        else $error("non-final event shown but job retired");

    a_adv_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("event issued but output register empty");

endmodule

### design/stick_to_direction_events_top.sv
// stick to direction events: analog stick samples in, direction button events out
// the first event of a sample passes the job queue, the job register and the output
// register to the result ports; one word per cycle in while the 2-slot job queue has room;
// each sample yields 0 to 4 events, sent one per cycle while the result port is popped
// reset (synchronous, active low): all direction flags cleared, queues emptied,
// threshold back to 16384
module stick_to_direction_events_top #(
    parameter int DEVICE_COUNT = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input word channel
    input  logic                push,
    output logic                full,
    input  stde_pkg::t_in_word  i_in_word,
    // result word channel
    output logic                empty,
    input  logic                pop,
    output stde_pkg::t_out_word o_out_word,
    // threshold register write
    input  logic                i_cfg_we,
    input  logic [14:0]         i_cfg_data
);

    // threshold register
    logic [14:0]         r_threshold;

    // front to queue
    logic                accept;
    logic                job_push;
    stde_pkg::t_job      job_in;

    // queue to back
    logic                job_valid;
    logic                job_full;
    logic                job_pop;
    stde_pkg::t_job      job_out;

    logic                out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= stde_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_data;
        end
    end

    // stall the front whenever the job queue has no free slot, even for words
    // that end up making no job; keeps the accept path short
    assign full   = job_full;
    assign accept = push && !job_full;

    // front: looks up the flags, classifies the sample, updates or clears the store
    stde_front #(
        .DEVICE_COUNT (DEVICE_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_word      (i_in_word),
        .i_threshold (r_threshold),
        .o_job_push  (job_push),
        .o_job       (job_in)
    );

    // short queue so front and back stall independently
    stde_job_fifo u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .i_pop   (job_pop),
        .o_valid (job_valid),
        .o_full  (job_full),
        .o_job   (job_out)
    );

    // back: serializes releases then presses into the output register
    stde_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_out_valid (out_valid),
        .o_out       (o_out_word)
    );

    assign empty = !out_valid;

endmodule
